/* rtl/polyev_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyev_pkg
// Shared widths, codes and the datapath control word for the polynomial
// evaluator.
// ----------------------------------------------------------------------------
package polyev_pkg;

  localparam int DATA_W     = 32;
  localparam int DEG_W      = 4;
  localparam int IDX_W      = 4;
  localparam int IN_TDATA_W = 72;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic start;
    logic mul_pw;
    logic acc_en;
    logic mul_cf;
    logic pw_clip_en;
    logic final_add;
  } dp_ctrl_t;

endpackage

/* rtl/polyev_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyev_cell
// One coefficient cell of the rotating store: load a word, or take the
// neighbor's word when the ring advances.
// ----------------------------------------------------------------------------
module polyev_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  polyev_pkg::word_t   wr_data,
  input  logic                shift_en,
  input  polyev_pkg::word_t   shift_in,
  output polyev_pkg::word_t   value
);
  import polyev_pkg::*;

  word_t value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else if (wr_en) begin
      value_r <= wr_data;
    end else if (shift_en) begin
      value_r <= shift_in;
    end
  end

  assign value = value_r;

endmodule

/* rtl/polyev_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyev_datapath
// Shared multiplier, power truncation and saturation, wide accumulator and
// final scaling with the constant term.
// ----------------------------------------------------------------------------
module polyev_datapath #(
  parameter int MAX_DEGREE = 15,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  polyev_pkg::dp_ctrl_t  ctrl,
  input  polyev_pkg::word_t     x_in,
  input  polyev_pkg::word_t     coef,
  output polyev_pkg::word_t     res_value,
  output logic                  res_sat
);
  import polyev_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DEGREE + 1);

  localparam logic signed [PROD_W-1:0] PROD_HI =
    {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] PROD_LO =
    {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_HI =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_LO =
    {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  word_t                    x_r;
  word_t                    pw_r;
  word_t                    c0_r;
  logic                     clip_r;
  logic signed [PROD_W-1:0] mul_r;
  logic signed [ACC_W-1:0]  acc_r;

  word_t                    op_a;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] pw_shift;
  word_t                    pw_fix;
  logic                     pw_clip;

  assign op_a = ctrl.mul_pw ? x_r : coef;
  assign prod = op_a * pw_r;

  always_comb begin
    pw_shift = mul_r >>> FRAC_BITS;
    pw_clip  = 1'b1;
    if (pw_shift > PROD_HI) begin
      pw_fix = WORD_MAX;
    end else if (pw_shift < PROD_LO) begin
      pw_fix = WORD_MIN;
    end else begin
      pw_fix  = pw_shift[DATA_W-1:0];
      pw_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x_r    <= x_in;
      pw_r   <= x_in;
      c0_r   <= coef;
      acc_r  <= '0;
      clip_r <= 1'b0;
    end else begin
      if (ctrl.mul_pw || ctrl.mul_cf) begin
        mul_r <= prod;
      end
      if (ctrl.acc_en) begin
        acc_r <= acc_r + ACC_W'(mul_r);
      end else if (ctrl.final_add) begin
        acc_r <= (acc_r >>> FRAC_BITS) + ACC_W'(c0_r);
      end
      if (ctrl.mul_cf) begin
        pw_r <= pw_fix;
        if (ctrl.pw_clip_en && pw_clip) begin
          clip_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_sat = 1'b1;
    if (acc_r > ACC_HI) begin
      res_value = WORD_MAX;
    end else if (acc_r < ACC_LO) begin
      res_value = WORD_MIN;
    end else begin
      res_value = acc_r[DATA_W-1:0];
      res_sat   = clip_r;
    end
  end

endmodule

/* rtl/polynomial_evaluator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Signed fixed-point polynomial evaluation over a rotating ring of
// coefficient cells and one shared multiplier.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                  tuser
// in       in   [3:0] coef_index [35:4] coef_value     [0] mode
//               [67:36] x_value [71:68] zero
// out      out  [31:0] result_value                    [0] saturated
// cfg      in   cfg_wr_data [3:0] degree               -
//
// A load word writes its cell and leaves the block idle. An evaluate word of
// effective degree D steps the shared multiplier through its terms, adds the
// constant term and rotates the coefficient ring back into place before the
// output load; D = 0 skips the multiplier.
// Reset clears the ring to zero and sets degree to 1.
// A result waiting on out stalls the next evaluate only at its output load.
// ----------------------------------------------------------------------------
module polynomial_evaluator #(
  parameter int MAX_DEGREE = 15,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [polyev_pkg::DEG_W-1:0]          cfg_wr_data, // [3:0] degree
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [polyev_pkg::IN_TDATA_W-1:0]     in_tdata,    // coef_index, coef_value, x_value
  input  logic                                  in_tuser,    // mode
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [polyev_pkg::DATA_W-1:0]         out_tdata,   // result_value
  output logic                                  out_tuser    // saturated
);
  import polyev_pkg::*;

  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int ROT_W = $clog2(DEPTH);
  localparam int K_W   = $clog2(MAX_DEGREE + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PA,
    S_PB,
    S_FIN,
    S_SUM,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [DEG_W-1:0]    degree_r;
  logic [K_W-1:0]      k_r;
  logic [K_W-1:0]      deg_r;
  logic [ROT_W-1:0]    rot_r;
  logic                out_tvalid_r;
  word_t               out_tdata_r;
  logic                out_tuser_r;

  logic [IDX_W-1:0]    in_idx;
  word_t               in_coef;
  word_t               in_x;
  logic                in_acc;
  logic                eval_go;
  logic [K_W-1:0]      deg_eff;
  logic                shift_en;
  logic                out_load;
  dp_ctrl_t            ctrl;
  word_t               res_value;
  logic                res_sat;
  word_t               cell_val [DEPTH];

  assign in_idx  = in_tdata[IDX_W-1:0];
  assign in_coef = in_tdata[IDX_W+DATA_W-1:IDX_W];
  assign in_x    = in_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign eval_go   = in_acc && (in_tuser == MODE_EVAL);

  always_comb begin
    if (32'(degree_r) > MAX_DEGREE) begin
      deg_eff = K_W'(MAX_DEGREE);
    end else begin
      deg_eff = K_W'(degree_r);
    end
  end

  assign shift_en = (state_r == S_PA) || ((state_r == S_DONE) && (rot_r != '0));
  assign out_load = (state_r == S_DONE) && (rot_r == '0) && (!out_tvalid_r || out_tready);

  always_comb begin
    ctrl            = '0;
    ctrl.start      = eval_go;
    ctrl.mul_pw     = (state_r == S_PA);
    ctrl.acc_en     = ((state_r == S_PA) && (k_r != K_W'(1))) || (state_r == S_FIN);
    ctrl.mul_cf     = (state_r == S_PB);
    ctrl.pw_clip_en = (state_r == S_PB) && (k_r < deg_r);
    ctrl.final_add  = (state_r == S_SUM);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % DEPTH;
    polyev_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (in_acc && (in_tuser == MODE_LOAD) && (32'(in_idx) == i)),
      .wr_data  (in_coef),
      .shift_en (shift_en),
      .shift_in (cell_val[NXT]),
      .value    (cell_val[i])
    );
  end

  polyev_datapath #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .x_in      (in_x),
    .coef      (cell_val[0]),
    .res_value (res_value),
    .res_sat   (res_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEG_W'(1);
    end else if (cfg_wr_en) begin
      degree_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      k_r          <= '0;
      deg_r        <= '0;
      rot_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (shift_en) begin
        rot_r <= (rot_r == ROT_W'(DEPTH - 1)) ? '0 : rot_r + 1'b1;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= res_value;
        out_tuser_r  <= res_sat;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (eval_go) begin
            deg_r <= deg_eff;
            k_r   <= K_W'(1);
            state_r <= (deg_eff == '0) ? S_SUM : S_PA;
          end
        end
        S_PA: begin
          state_r <= S_PB;
        end
        S_PB: begin
          if (k_r == deg_r) begin
            state_r <= S_FIN;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_PA;
          end
        end
        S_FIN: begin
          state_r <= S_SUM;
        end
        S_SUM: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_ring_aligned_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (rot_r == '0))
    else $error("coefficient ring not aligned while idle");

  a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PA) || (state_r == S_PB)) |-> ((k_r != '0) && (k_r <= deg_r)))
    else $error("term counter out of range");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    eval_go |=> !in_tready)
    else $error("input accepted during evaluation");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == MODE_LOAD) && !out_tvalid_r) |=> !out_tvalid_r)
    else $error("load word produced a result");

endmodule
